// ===== rtl/mer_pkg.sv =====
`timescale 1ns / 1ps
package mer_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int AXIS_BITS_DEF = 11;
  localparam int SIZE_W = 13;
  localparam int PIX_W = 12;
  localparam int COLOR_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int DEC_W = 48;
  localparam logic [SIZE_W-1:0] WIDTH_RST = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_DRAW = 2'd0,
    ST_CLIPPED = 2'd1,
    ST_DONE = 2'd2,
    ST_LOADED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_A,
    S_LOAD_B,
    S_LOAD_D,
    S_CORR,
    S_CHECK,
    S_EMIT,
    S_UPD_Y,
    S_UPD_X,
    S_UPD_D,
    S_OUT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PIX_W-1:0]  x_lo;
    logic [PIX_W-1:0]  x_hi;
    logic [PIX_W-1:0]  y_lo;
    logic [PIX_W-1:0]  y_hi;
    logic [COLOR_W-1:0] pixel_color;
    logic              last;
  } result_t;

  // clamp a screen size write to 1..4096
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = {{(SIZE_W-1){1'b0}}, 1'b1};
    else if (v > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction
endpackage

// ===== rtl/mer_in_if.sv =====
`timescale 1ns / 1ps
interface mer_in_if #(parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
                      parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF);
  logic valid;
  logic ready;
  logic cmd;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [AXIS_BITS-1:0] semi_x;
  logic [AXIS_BITS-1:0] semi_y;
  logic filled;
  logic [7:0] color;
  modport source(output valid, cmd, center_x, center_y, semi_x, semi_y, filled, color,
                 input ready);
  modport sink(input valid, cmd, center_x, center_y, semi_x, semi_y, filled, color,
               output ready);
endinterface

// ===== rtl/mer_out_if.sv =====
`timescale 1ns / 1ps
interface mer_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [11:0] x_lo;
  logic [11:0] x_hi;
  logic [11:0] y_lo;
  logic [11:0] y_hi;
  logic [7:0] pixel_color;
  logic last;
  modport source(output valid, status, x_lo, x_hi, y_lo, y_hi, pixel_color, last,
                 input ready);
  modport sink(input valid, status, x_lo, x_hi, y_lo, y_hi, pixel_color, last,
               output ready);
endinterface

// ===== rtl/mer_cfg_if.sv =====
`timescale 1ns / 1ps
interface mer_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [12:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/midpoint_ellipse_rasterizer_top.sv =====
`timescale 1ns / 1ps
// Channel | dir | payload
// in_     | in  | cmd, center_x, center_y, semi_x, semi_y, filled, color
// out_    | out | status, x_lo, x_hi, y_lo, y_hi, pixel_color, last
// cfg_    | in  | index, data (screen width / height)
// Acceptance to next acceptance: a load, a step with no ellipse, a finishing
// step and a drawing step each run through their own sequence of states;
// all four emit slots are always walked. A shared multiplier and a shared adder
// are reused by the sequencer; each result passes through the output register.
// Reset (rst_n low, synchronous) clears control state, screen size 640x480.
// in_ready is low while an item is in work or a result waits in the output register.
module midpoint_ellipse_rasterizer_top #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  mer_in_if.sink   in_ch,
  mer_out_if.source out_ch,
  mer_cfg_if.sink  cfg_ch
);
  import mer_pkg::*;

  localparam int SQ_W = 2 * AXIS_BITS;
  localparam int DW = 2 * SQ_W + 4;            // decision / accumulator width
  localparam int CW = COORD_BITS + AXIS_BITS + 2;
  localparam int OXW = AXIS_BITS + 1;

  // config
  logic [SIZE_W-1:0] scr_w_r, scr_h_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= WIDTH_RST;
      scr_h_r <= HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WIDTH:  scr_w_r <= clamp_size(cfg_ch.data);
        REG_HEIGHT: scr_h_r <= clamp_size(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // ellipse state
  state_t state_r, state_nxt;
  logic signed [COORD_BITS-1:0] ctr_x_r, ctr_y_r;
  logic [AXIS_BITS-1:0] sa_r, sb_r;
  logic signed [OXW:0] off_x_r, off_y_r;
  logic signed [DW-1:0] dec_r, sxa_r, sya_r, asq_r, bsq_r, t_r;
  logic reg2_r, active_r, fill_r;
  logic [7:0] col_r;
  logic [1:0] k_r;     // emit slot
  logic [2:0] n_r;     // results queued
  logic reg2_dec_r;

  // result queue (four slots, fixed positions)
  result_t q_r [4];
  logic [1:0] rd_r;
  result_t out_r;
  logic out_v_r;

  // shared multiplier input
  logic [AXIS_BITS-1:0] mul_a, mul_b;
  logic [SQ_W-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // a^2 * b for the initial decision terms
  logic [SQ_W+AXIS_BITS-1:0] t_mul;
  assign t_mul = asq_r[SQ_W-1:0] * sb_r;

  // shared adder
  logic signed [DW-1:0] add_a, add_b, add_s;
  assign add_s = add_a + add_b;

  // candidate geometry for current slot
  logic signed [CW-1:0] cx, cy, ox, oy, xl, xh, yl, yh;
  logic exist, vis;
  logic [PIX_W-1:0] cxl, cxh, cyl, cyh;
  mer_clip #(.CW(CW)) u_clip (
    .xl(xl), .xh(xh), .yl(yl), .yh(yh), .scr_w(scr_w_r), .scr_h(scr_h_r),
    .vis(vis), .cxl(cxl), .cxh(cxh), .cyl(cyl), .cyh(cyh)
  );

  always_comb begin
    cx = CW'(ctr_x_r);
    cy = CW'(ctr_y_r);
    ox = CW'(off_x_r);
    oy = CW'(off_y_r);
    xl = cx; xh = cx; yl = cy; yh = cy;
    exist = 1'b0;
    if (!fill_r) begin
      case (k_r)
        2'd0: begin xl = cx + ox; yl = cy + oy; exist = 1'b1; end
        2'd1: begin xl = cx - ox; yl = cy + oy; exist = (off_x_r != 0); end
        2'd2: begin xl = cx + ox; yl = cy - oy; exist = (off_y_r != 0); end
        default: begin xl = cx - ox; yl = cy - oy;
          exist = (off_x_r != 0) && (off_y_r != 0); end
      endcase
      // x=0 case: slot 2 gives (cx, cy-y) too, slot 1 and 3 suppressed
      xh = xl; yh = yl;
    end else begin
      if (off_x_r != 0) begin
        xl = cx - ox; xh = cx + ox;
        yl = (k_r == 2'd0) ? cy + oy : cy - oy; yh = yl;
        exist = (k_r == 2'd0) || (k_r == 2'd1 && off_y_r != 0);
      end else begin
        yl = cy - (oy < 0 ? -oy : oy); yh = cy + (oy < 0 ? -oy : oy);
        exist = (k_r == 2'd0);
      end
    end
  end

  logic acc_in;
  assign in_ch.ready = (state_r == S_IDLE) && !out_v_r;
  assign acc_in = in_ch.valid && in_ch.ready;

  // adder and multiplier operand select
  always_comb begin
    add_a = '0;
    add_b = '0;
    mul_a = sa_r;
    mul_b = sa_r;
    case (state_r)
      S_LOAD_A: begin mul_a = sa_r; mul_b = sa_r; end
      S_LOAD_B: begin mul_a = sb_r; mul_b = sb_r; end
      S_LOAD_D: begin add_a = bsq_r; add_b = (asq_r >>> 2) - t_r; end
      S_CORR:   begin add_a = sxa_r; add_b = sya_r; end
      S_UPD_Y:  begin add_a = sya_r; add_b = -(asq_r <<< 1); end
      S_UPD_X:  begin add_a = sxa_r; add_b = bsq_r <<< 1; end
      default: ;
    endcase
  end

  logic signed [DW-1:0] diff3, half1, corr;
  always_comb begin
    diff3 = (asq_r - bsq_r) * 3;
    half1 = (diff3 < 0) ? -((-diff3) >>> 1) : (diff3 >>> 1);
    corr = half1 - t_r;
    corr = (corr < 0) ? -((-corr) >>> 1) : (corr >>> 1);
  end

  result_t res;
  always_comb begin
    res = '0;
    res.status = ST_DRAW;
    res.x_lo = cxl; res.x_hi = cxh; res.y_lo = cyl; res.y_hi = cyh;
    res.pixel_color = col_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc_in) begin
        if (in_ch.cmd == CMD_LOAD) state_nxt = S_LOAD_A;
        else if (!active_r) state_nxt = S_OUT;
        else state_nxt = S_CORR;
      end
      S_LOAD_A: state_nxt = S_LOAD_B;
      S_LOAD_B: state_nxt = S_LOAD_D;
      S_LOAD_D: state_nxt = S_OUT;
      S_CORR:   state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (reg2_r && off_y_r < 0) ? S_OUT : S_EMIT;
      S_EMIT:   if (k_r == 2'd3) state_nxt = S_UPD_Y;
      S_UPD_Y:  state_nxt = S_UPD_X;
      S_UPD_X:  state_nxt = S_UPD_D;
      S_UPD_D:  state_nxt = S_OUT;
      S_OUT:    state_nxt = S_FLUSH;
      S_FLUSH:  if (!out_v_r && rd_r == n_r[1:0] && n_r != 3'd0) state_nxt = S_FLUSH;
                else if (!out_v_r && (n_r == 3'd0)) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  logic out_fire;
  assign out_fire = out_v_r && out_ch.ready;

  // output register: load the next queued result when empty or draining
  logic out_load;
  result_t out_pick;
  assign out_load = (state_r == S_FLUSH) && (!out_v_r || out_fire) &&
                    (n_r != 3'd0) && ({1'b0, rd_r} < n_r);
  always_comb begin
    out_pick = q_r[rd_r];
    out_pick.last = ({1'b0, rd_r} + 3'd1 == n_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
      out_r <= out_pick;
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      active_r <= 1'b0;
      reg2_r <= 1'b0;
      n_r <= '0;
      k_r <= '0;
      rd_r <= '0;
      fill_r <= 1'b0;
      col_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (acc_in) begin
          k_r <= '0; rd_r <= '0;
          if (in_ch.cmd == CMD_LOAD) begin
            ctr_x_r <= in_ch.center_x;
            ctr_y_r <= in_ch.center_y;
            sa_r <= in_ch.semi_x;
            sb_r <= in_ch.semi_y;
            fill_r <= in_ch.filled;
            col_r <= in_ch.color;
            reg2_r <= 1'b0;
            active_r <= 1'b1;
            off_x_r <= '0;
            off_y_r <= (OXW+1)'(in_ch.semi_y);
            sxa_r <= '0;
            q_r[0] <= '{status: ST_LOADED, last: 1'b1, default: '0};
            n_r <= 3'd1;
          end else if (!active_r) begin
            q_r[0] <= '{status: ST_DONE, last: 1'b1, default: '0};
            n_r <= 3'd1;
          end else begin
            n_r <= '0;
          end
        end
        S_LOAD_A: asq_r <= DW'(mul_p);
        S_LOAD_B: begin
          bsq_r <= DW'(mul_p);
          t_r <= DW'(t_mul);
        end
        S_LOAD_D: begin
          dec_r <= add_s;
          sya_r <= t_r <<< 1;
        end
        S_CORR: begin
          t_r <= add_s;
        end
        S_CHECK: begin
          if (!reg2_r && !(sxa_r < sya_r)) begin
            dec_r <= dec_r + corr;
            reg2_r <= 1'b1;
            reg2_dec_r <= 1'b1;
          end
          if (!reg2_r && !(sxa_r < sya_r) && off_y_r < 0 ||
              reg2_r && off_y_r < 0) begin
            active_r <= 1'b0;
            q_r[0] <= '{status: ST_DONE, last: 1'b1, default: '0};
            n_r <= 3'd1;
          end
        end
        S_EMIT: begin
          if (exist && vis) begin
            q_r[n_r[1:0]] <= res;
            n_r <= n_r + 3'd1;
          end
          k_r <= k_r + 2'd1;
        end
        S_UPD_Y: begin
          reg2_dec_r <= reg2_r ? (dec_r < 0) : (dec_r > 0);
          if (!reg2_r ? (dec_r > 0) : 1'b1) begin
            off_y_r <= off_y_r - 1'b1;
            sya_r <= add_s;
            dec_r <= reg2_r ? dec_r + asq_r - add_s : dec_r - add_s;
          end
        end
        S_UPD_X: begin
          if (!reg2_r || reg2_dec_r) begin
            off_x_r <= off_x_r + 1'b1;
            sxa_r <= add_s;
            dec_r <= reg2_r ? dec_r + add_s : dec_r + bsq_r + add_s;
          end
        end
        S_UPD_D: begin
          if (n_r == 3'd0) begin
            q_r[0] <= '{status: ST_CLIPPED, last: 1'b1, default: '0};
            n_r <= 3'd1;
          end
        end
        S_FLUSH: if (out_load) begin
          rd_r <= rd_r + 2'd1;
          if ({1'b0, rd_r} + 3'd1 == n_r) n_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.status = out_r.status;
  assign out_ch.x_lo = out_r.x_lo;
  assign out_ch.x_hi = out_r.x_hi;
  assign out_ch.y_lo = out_r.y_lo;
  assign out_ch.y_hi = out_r.y_hi;
  assign out_ch.pixel_color = out_r.pixel_color;
  assign out_ch.last = out_r.last;

  // checks
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> out_v_r) else $error("result dropped");
  a_nonraw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status != ST_DRAW) |-> out_r.last) else $error("status not last");
endmodule

// ===== rtl/mer_clip.sv =====
`timescale 1ns / 1ps
// Clips one rectangle against the screen; result valid if any part is visible.
module mer_clip #(
  parameter int CW = 20
) (
  input  logic signed [CW-1:0]            xl,
  input  logic signed [CW-1:0]            xh,
  input  logic signed [CW-1:0]            yl,
  input  logic signed [CW-1:0]            yh,
  input  logic [mer_pkg::SIZE_W-1:0]      scr_w,
  input  logic [mer_pkg::SIZE_W-1:0]      scr_h,
  output logic                            vis,
  output logic [mer_pkg::PIX_W-1:0]       cxl,
  output logic [mer_pkg::PIX_W-1:0]       cxh,
  output logic [mer_pkg::PIX_W-1:0]       cyl,
  output logic [mer_pkg::PIX_W-1:0]       cyh
);
  import mer_pkg::*;
  logic signed [CW-1:0] wm1, hm1, a, b, c, d;
  always_comb begin
    wm1 = CW'($signed({1'b0, scr_w})) - CW'(1);
    hm1 = CW'($signed({1'b0, scr_h})) - CW'(1);
    vis = !(xh < 0 || xl > wm1 || yh < 0 || yl > hm1);
    a = (xl < 0) ? '0 : xl;
    b = (xh > wm1) ? wm1 : xh;
    c = (yl < 0) ? '0 : yl;
    d = (yh > hm1) ? hm1 : yh;
    cxl = a[PIX_W-1:0];
    cxh = b[PIX_W-1:0];
    cyl = c[PIX_W-1:0];
    cyh = d[PIX_W-1:0];
  end
endmodule

// ===== dv/mer_checker.sv =====
`timescale 1ns / 1ps
module mer_checker (
  input  logic clk,
  input  logic rst_n,
  mer_in_if    in_ch,
  mer_out_if   out_ch,
  mer_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import mer_pkg::*;

  // screen size as the block sees it
  longint scr_w, scr_h;

  // ellipse tracer state
  longint ctr_x, ctr_y, off_x, off_y;
  longint dec_var, dx_acc, dy_acc, a_sq, b_sq;
  bit     region_two, drawing, fill_on;
  logic [COLOR_W-1:0] ink;

  result_t pix_q[$];

  function automatic longint size_clamp(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return longint'(v);
  endfunction

  function automatic void push_status(status_t st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    pix_q.push_back(r);
  endfunction

  // clip a rectangle to the screen; returns 1 if something was queued
  function automatic int push_rect(longint xl, longint xh, longint yl, longint yh);
    result_t r;
    if (xh < 0 || xl > scr_w - 1 || yh < 0 || yl > scr_h - 1) return 0;
    if (xl < 0) xl = 0;
    if (xh > scr_w - 1) xh = scr_w - 1;
    if (yl < 0) yl = 0;
    if (yh > scr_h - 1) yh = scr_h - 1;
    r = '0;
    r.status = ST_DRAW;
    r.x_lo = xl[PIX_W-1:0];
    r.x_hi = xh[PIX_W-1:0];
    r.y_lo = yl[PIX_W-1:0];
    r.y_hi = yh[PIX_W-1:0];
    r.pixel_color = ink;
    pix_q.push_back(r);
    return 1;
  endfunction

  // one accepted item: update the tracer and queue its results
  function automatic void trace_item();
    longint a, b, x, y, ax, ay;
    int n;
    n = 0;
    if (in_ch.cmd == CMD_LOAD) begin
      a = longint'(in_ch.semi_x);
      b = longint'(in_ch.semi_y);
      ctr_x = longint'(in_ch.center_x);
      ctr_y = longint'(in_ch.center_y);
      a_sq = a * a;
      b_sq = b * b;
      off_x = 0;
      off_y = b;
      dec_var = b_sq - a_sq * b + a_sq / 4;
      dx_acc = 0;
      dy_acc = 2 * a_sq * b;
      region_two = 0;
      drawing = 1;
      fill_on = in_ch.filled;
      ink = in_ch.color;
      push_status(ST_LOADED);
      return;
    end
    if (!drawing) begin
      push_status(ST_DONE);
      return;
    end
    // region switch applies the correction term once
    if (!region_two && !(dx_acc < dy_acc)) begin
      dec_var += (3 * (a_sq - b_sq) / 2 - (dx_acc + dy_acc)) / 2;
      region_two = 1;
    end
    if (region_two && off_y < 0) begin
      drawing = 0;
      push_status(ST_DONE);
      return;
    end
    x = off_x;
    y = off_y;
    if (!fill_on) begin
      if (x != 0) begin
        n += push_rect(ctr_x + x, ctr_x + x, ctr_y + y, ctr_y + y);
        n += push_rect(ctr_x - x, ctr_x - x, ctr_y + y, ctr_y + y);
        if (y != 0) begin
          n += push_rect(ctr_x + x, ctr_x + x, ctr_y - y, ctr_y - y);
          n += push_rect(ctr_x - x, ctr_x - x, ctr_y - y, ctr_y - y);
        end
      end else begin
        n += push_rect(ctr_x, ctr_x, ctr_y + y, ctr_y + y);
        if (y != 0) n += push_rect(ctr_x, ctr_x, ctr_y - y, ctr_y - y);
      end
    end else begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (x != 0) begin
        n += push_rect(ctr_x - ax, ctr_x + ax, ctr_y + y, ctr_y + y);
        if (y != 0) n += push_rect(ctr_x - ax, ctr_x + ax, ctr_y - y, ctr_y - y);
      end else begin
        n += push_rect(ctr_x, ctr_x, ctr_y - ay, ctr_y + ay);
      end
    end
    // decision update
    if (!region_two) begin
      if (dec_var > 0) begin
        off_y--;
        dy_acc -= 2 * a_sq;
        dec_var -= dy_acc;
      end
      off_x++;
      dx_acc += 2 * b_sq;
      dec_var += b_sq + dx_acc;
    end else begin
      if (dec_var < 0) begin
        off_x++;
        dx_acc += 2 * b_sq;
        dec_var += dx_acc;
      end
      off_y--;
      dy_acc -= 2 * a_sq;
      dec_var += a_sq - dy_acc;
    end
    if (n == 0) push_status(ST_CLIPPED);
    else pix_q[pix_q.size()-1].last = 1'b1;
  endfunction

  function automatic void field_check(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      scr_w = 640;
      scr_h = 480;
      ctr_x = 0; ctr_y = 0; off_x = 0; off_y = 0;
      dec_var = 0; dx_acc = 0; dy_acc = 0; a_sq = 0; b_sq = 0;
      region_two = 0; drawing = 0; fill_on = 0; ink = '0;
      pix_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_WIDTH) scr_w = size_clamp(cfg_ch.data);
        else scr_h = size_clamp(cfg_ch.data);
      end
      // compare before predicting: a new item cannot answer in its own cycle
      if (out_ch.valid && out_ch.ready) begin
        if (pix_q.size() == 0) begin
          $error("result with no expected item waiting");
          fail_count++;
        end else begin
          e = pix_q.pop_front();
          field_check("status", e.status, out_ch.status);
          field_check("x_lo", e.x_lo, out_ch.x_lo);
          field_check("x_hi", e.x_hi, out_ch.x_hi);
          field_check("y_lo", e.y_lo, out_ch.y_lo);
          field_check("y_hi", e.y_hi, out_ch.y_hi);
          field_check("pixel_color", e.pixel_color, out_ch.pixel_color);
          field_check("last", e.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) trace_item();
    end
    pending = pix_q.size();
  end
endmodule

// ===== dv/midpoint_ellipse_rasterizer_top_test.sv =====
`timescale 1ns / 1ps
module midpoint_ellipse_rasterizer_top_test;
  import mer_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 112;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   send_idle;
  int   recv_idle;
  int   item_count;
  int   scr_w_now;
  int   scr_h_now;

  mer_in_if  in_if ();
  mer_out_if out_if ();
  mer_cfg_if cfg_if ();

  midpoint_ellipse_rasterizer_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  mer_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_ch    (cfg_if),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("midpoint_ellipse_rasterizer_top_test failed");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // drive one item; called just after a rising edge
  task automatic send_item(logic cmd, logic signed [15:0] cx, logic signed [15:0] cy,
                           logic [10:0] a, logic [10:0] b, logic f, logic [7:0] col);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.center_x <= cx;
    in_if.center_y <= cy;
    in_if.semi_x   <= a;
    in_if.semi_y   <= b;
    in_if.filled   <= f;
    in_if.color    <= col;
    do @(posedge clk); while (!in_if.ready);
    item_count++;
  endtask

  // step item with junk in the load-only fields
  task automatic send_step();
    send_item(CMD_STEP, 16'($urandom), 16'($urandom), 11'($urandom), 11'($urandom),
              1'($urandom), 8'($urandom));
  endtask

  task automatic steps(int n);
    repeat (n) send_step();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain, then settle before touching registers
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_screen(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    scr_w_now = (w == 0) ? 1 : (w > 4096) ? 4096 : int'(w);
    scr_h_now = (h == 0) ? 1 : (h > 4096) ? 4096 : int'(h);
  endtask

  // load an ellipse and trace it, usually to the end
  task automatic random_ellipse();
    logic [10:0] a, b;
    logic signed [15:0] cx, cy;
    int n;
    a = ($urandom_range(15) == 0) ? 11'($urandom) : 11'($urandom_range(12));
    b = ($urandom_range(15) == 0) ? 11'($urandom) : 11'($urandom_range(12));
    if ($urandom_range(9) == 0) begin
      cx = 16'($urandom);
      cy = 16'($urandom);
    end else begin
      cx = 16'(int'($urandom_range(scr_w_now + 40)) - 20);
      cy = 16'(int'($urandom_range(scr_h_now + 40)) - 20);
    end
    send_item(CMD_LOAD, cx, cy, a, b, 1'($urandom), 8'($urandom));
    n = int'(a) + int'(b) + 3;
    if (n > 40) n = 40;
    if ($urandom_range(4) == 0) n = $urandom_range(n);
    steps(n);
  endtask

  task automatic random_phase();
    int target;
    target = item_count + ITEMS_PER_PHASE;
    while (item_count < target) begin
      if ($urandom_range(9) == 0) steps($urandom_range(1, 3));
      else random_ellipse();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    item_count = 0;
    send_idle = 28;
    recv_idle = 84;
    scr_w_now = 640;
    scr_h_now = 480;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_LOAD;
    in_if.center_x = '0;
    in_if.center_y = '0;
    in_if.semi_x = '0;
    in_if.semi_y = '0;
    in_if.filled = 1'b0;
    in_if.color = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_WIDTH;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no load, default screen
    send_step();
    wait_idle();
    set_screen(13'd64, 13'd48);
    // outline ellipse traced to its end and beyond
    send_item(CMD_LOAD, 16'sd20, 16'sd20, 11'd6, 11'd4, 1'b0, 8'hFF);
    steps(16);
    // extreme centre and axes, abandoned by the next load
    send_item(CMD_LOAD, -16'sd32768, 16'sd32767, 11'd2047, 11'd2047, 1'b1, 8'h00);
    steps(2);
    // zero horizontal axis, filled: vertical spans until finished
    send_item(CMD_LOAD, 16'sd5, 16'sd5, 11'd0, 11'd3, 1'b1, 8'h5A);
    steps(5);
    // zero vertical axis at the top edge, outline
    send_item(CMD_LOAD, 16'sd30, 16'sd0, 11'd4, 11'd0, 1'b0, 8'hA5);
    steps(3);
    random_phase();

    wait_idle();
    set_screen(13'd8191, 13'd0);
    send_idle = 84;
    recv_idle = 28;
    random_phase();

    wait_idle();
    set_screen(13'(80 + $urandom_range(200)), 13'(60 + $urandom_range(200)));
    send_idle = 0;
    recv_idle = 0;
    random_phase();

    wait_idle();
    if (fail_count == 0) begin
      $display("midpoint_ellipse_rasterizer_top_test passed");
    end else begin
      $display("midpoint_ellipse_rasterizer_top_test failed");
    end
    $finish;
  end
endmodule
